### src/mass_spring_chain_euler_step_top_macros.svh
// Assertion macros for the mass-spring chain block.
// Used by the port checker; needs nothing else.
`ifndef MASS_SPRING_CHAIN_EULER_STEP_TOP_MACROS_SVH
`define MASS_SPRING_CHAIN_EULER_STEP_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MSC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define MSC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/msc_pkg.sv
// Package for the mass-spring chain block: codes, defaults, shared types.
// Depends on nothing.
`timescale 1ns / 1ps

package msc_pkg;

    localparam int MAX_NODES_DEF   = 16;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int MAX_SUBSTEPS    = 64;
    localparam int COEF_W          = 31;

    localparam logic [1:0] FUNC_ADVANCE = 2'd0;
    localparam logic [1:0] FUNC_SET_POS = 2'd1;
    localparam logic [1:0] FUNC_SET_VEL = 2'd2;

    localparam logic [2:0] CFG_NODE_COUNT   = 3'd0;
    localparam logic [2:0] CFG_SUBSTEPS     = 3'd1;
    localparam logic [2:0] CFG_SUBSTEP_TIME = 3'd2;
    localparam logic [2:0] CFG_STIFFNESS    = 3'd3;
    localparam logic [2:0] CFG_INVERSE_MASS = 3'd4;
    localparam logic [2:0] CFG_DAMPING      = 3'd5;

    typedef struct packed {
        logic [4:0]        node_count;
        logic [6:0]        substeps;
        logic [COEF_W-1:0] substep_time;
        logic [COEF_W-1:0] stiffness;
        logic [COEF_W-1:0] inverse_mass;
        logic [COEF_W-1:0] damping;
    } cfg_t;

    typedef struct packed {
        logic               start;
        logic [1:0]         func;
        logic [3:0]         node_index;
        logic signed [31:0] set_value;
    } cmd_t;

    typedef struct packed {
        logic idle;
        logic done;
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SS0,
        ST_SS1,
        ST_SS2,
        ST_RD,
        ST_CAP,
        ST_K,
        ST_D,
        ST_IM,
        ST_V,
        ST_X,
        ST_DONE
    } state_t;

endpackage

### src/mass_spring_chain_euler_step_top.sv
// Top level of the mass-spring chain block: ports, configuration, result register.
// Depends on msc_pkg and msc_core.
`timescale 1ns / 1ps

// One request at a time. A set request (position or velocity of one node)
// or the unused code goes from acceptance straight to the done state. An
// advance request walks every moving node once per substep through a
// single shared multiplier and a position and a velocity RAM, with the
// multiplier sequence per node (stiffness, damping on the last node,
// inverse mass, time step for velocity, time step for position). Each
// result is node 1's position after the request. A new request is taken
// once the block is idle and the result register is free or being
// drained. Configuration writes are always ready and should be issued only
// while the block is idle. No clearing pass after reset.
module mass_spring_chain_euler_step_top #(
    parameter int MAX_NODES   = msc_pkg::MAX_NODES_DEF,
    parameter int VALUE_WIDTH = msc_pkg::VALUE_WIDTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_func,
    input  logic [3:0]         s_node_index,
    input  logic signed [31:0] s_set_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_sample,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    msc_pkg::cfg_t    cfg_reg, cfg_next;
    msc_pkg::cmd_t    cmd;
    msc_pkg::status_t status;

    logic signed [VALUE_WIDTH-1:0] pos1;
    logic                          m_valid_reg, m_valid_next;
    logic signed [31:0]            m_sample_reg, m_sample_next;

    // Configuration writes land directly.
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                msc_pkg::CFG_NODE_COUNT:   cfg_next.node_count   = cfg_data[4:0];
                msc_pkg::CFG_SUBSTEPS:     cfg_next.substeps     = cfg_data[6:0];
                msc_pkg::CFG_SUBSTEP_TIME: cfg_next.substep_time = cfg_data[30:0];
                msc_pkg::CFG_STIFFNESS:    cfg_next.stiffness    = cfg_data[30:0];
                msc_pkg::CFG_INVERSE_MASS: cfg_next.inverse_mass = cfg_data[30:0];
                msc_pkg::CFG_DAMPING:      cfg_next.damping      = cfg_data[30:0];
                default: begin
                end
            endcase
        end
    end

    // Accept only when idle and the result slot frees up by this edge.
    assign s_ready = status.idle && (!m_valid_reg || m_ready);

    assign cmd.start      = s_valid && s_ready;
    assign cmd.func       = s_func;
    assign cmd.node_index = s_node_index;
    assign cmd.set_value  = s_set_value;

    msc_core #(.MAX_NODES(MAX_NODES), .VALUE_WIDTH(VALUE_WIDTH)) u_core (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg), .cmd(cmd),
        .status(status), .pos1(pos1)
    );

    // Result register: load on done, drop on handshake.
    always_comb begin
        m_valid_next  = m_valid_reg;
        m_sample_next = m_sample_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (status.done) begin
            m_valid_next  = 1'b1;
            m_sample_next = 32'(pos1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.node_count   <= 5'd3;
            cfg_reg.substeps     <= 7'd1;
            cfg_reg.substep_time <= '0;
            cfg_reg.stiffness    <= 31'd16777216;
            cfg_reg.inverse_mass <= 31'd16777216;
            cfg_reg.damping      <= '0;
            m_valid_reg          <= 1'b0;
        end else begin
            cfg_reg     <= cfg_next;
            m_valid_reg <= m_valid_next;
        end
        m_sample_reg <= m_sample_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_sample = m_sample_reg;

endmodule

### src/msc_ram.sv
// Generic single-port-write, registered-read RAM.
// No dependencies.
`timescale 1ns / 1ps

module msc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/msc_core.sv
// Sequencer and datapath: walks the chain node by node out of two RAMs.
// Depends on msc_pkg and msc_ram.
`timescale 1ns / 1ps

module msc_core #(
    parameter int MAX_NODES   = msc_pkg::MAX_NODES_DEF,
    parameter int VALUE_WIDTH = msc_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  msc_pkg::cfg_t                 cfg,
    input  msc_pkg::cmd_t                 cmd,
    output msc_pkg::status_t              status,
    output logic signed [VALUE_WIDTH-1:0] pos1
);

    localparam int NW   = $clog2(MAX_NODES);
    localparam int VW   = VALUE_WIDTH;
    localparam int AW   = VW + 2;
    localparam int FRAC = VW - 8;
    localparam int PW   = AW + msc_pkg::COEF_W + 1;

    msc_pkg::state_t state_reg, state_next;

    logic [NW-1:0]        i_reg, i_next;
    logic [6:0]           step_reg, step_next;
    logic signed [VW-1:0] xl_reg, xl_next, xc_reg, xc_next, xr_reg, xr_next;
    logic signed [VW-1:0] v_reg, v_next, acc_reg, acc_next, pos1_reg, pos1_next;
    logic [MAX_NODES-1:0] pv_reg, pv_next, vv_reg, vv_next;
    logic                 pvq_reg, vvq_reg;

    logic          pos_we, vel_we;
    logic [NW-1:0] pos_waddr, vel_waddr, pos_raddr, vel_raddr;
    logic [VW-1:0] pos_wdata, vel_wdata, pos_q, vel_q;
    logic signed [VW-1:0] pos_rd, vel_rd;

    logic [NW-1:0] last;
    logic [6:0]    steps_eff;
    logic          is_last, set_ok;
    logic signed [VW-1:0] set_val;

    logic signed [AW-1:0]             mul_a;
    logic [msc_pkg::COEF_W-1:0]       mul_c;
    logic signed [PW-1:0]             prod;
    logic signed [VW-1:0]             mul_res;
    logic signed [VW-1:0]             x_new;

    msc_ram #(.WIDTH(VW), .DEPTH(MAX_NODES)) u_pos_ram (
        .aclk(aclk), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
        .raddr(pos_raddr), .rdata(pos_q)
    );

    msc_ram #(.WIDTH(VW), .DEPTH(MAX_NODES)) u_vel_ram (
        .aclk(aclk), .we(vel_we), .waddr(vel_waddr), .wdata(vel_wdata),
        .raddr(vel_raddr), .rdata(vel_q)
    );

    // Never-written entries read as zero.
    assign pos_rd = pvq_reg ? signed'(pos_q) : '0;
    assign vel_rd = vvq_reg ? signed'(vel_q) : '0;

    // Saturate the configured sizes.
    always_comb begin
        if (int'(cfg.node_count) > MAX_NODES) begin
            last = NW'(MAX_NODES - 1);
        end else if (cfg.node_count < 5'd3) begin
            last = NW'(2);
        end else begin
            last = NW'(cfg.node_count - 5'd1);
        end
        if (cfg.substeps == 7'd0) begin
            steps_eff = 7'd1;
        end else if (cfg.substeps > 7'(msc_pkg::MAX_SUBSTEPS)) begin
            steps_eff = 7'(msc_pkg::MAX_SUBSTEPS);
        end else begin
            steps_eff = cfg.substeps;
        end
    end

    assign is_last = (i_reg == last);
    assign set_ok  = int'(cmd.node_index) < MAX_NODES;
    assign set_val = VW'(cmd.set_value);

    // Shared multiplier: floor(a * c / 2^FRAC), wrapped to VW bits.
    always_comb begin
        mul_a = AW'(v_reg);
        mul_c = cfg.substep_time;
        case (state_reg)
            msc_pkg::ST_K: begin
                if (is_last) begin
                    mul_a = AW'(xl_reg) - AW'(xc_reg);
                end else begin
                    mul_a = AW'(xl_reg) + AW'(xr_reg) - (AW'(xc_reg) <<< 1);
                end
                mul_c = cfg.stiffness;
            end
            msc_pkg::ST_D: begin
                mul_a = AW'(v_reg);
                mul_c = cfg.damping;
            end
            msc_pkg::ST_IM: begin
                mul_a = AW'(acc_reg);
                mul_c = cfg.inverse_mass;
            end
            msc_pkg::ST_V: begin
                mul_a = AW'(acc_reg);
                mul_c = cfg.substep_time;
            end
            default: begin
                mul_a = AW'(v_reg);
                mul_c = cfg.substep_time;
            end
        endcase
    end

    assign prod    = PW'(mul_a) * signed'(PW'({1'b0, mul_c}));
    assign mul_res = prod[FRAC+VW-1:FRAC];
    assign x_new   = xc_reg + mul_res;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            msc_pkg::ST_IDLE: begin
                if (cmd.start) begin
                    state_next = (cmd.func == msc_pkg::FUNC_ADVANCE) ? msc_pkg::ST_SS0
                                                                     : msc_pkg::ST_DONE;
                end
            end
            msc_pkg::ST_SS0:  state_next = msc_pkg::ST_SS1;
            msc_pkg::ST_SS1:  state_next = msc_pkg::ST_SS2;
            msc_pkg::ST_SS2:  state_next = msc_pkg::ST_RD;
            msc_pkg::ST_RD:   state_next = msc_pkg::ST_CAP;
            msc_pkg::ST_CAP:  state_next = msc_pkg::ST_K;
            msc_pkg::ST_K:    state_next = is_last ? msc_pkg::ST_D : msc_pkg::ST_IM;
            msc_pkg::ST_D:    state_next = msc_pkg::ST_IM;
            msc_pkg::ST_IM:   state_next = msc_pkg::ST_V;
            msc_pkg::ST_V:    state_next = msc_pkg::ST_X;
            msc_pkg::ST_X: begin
                if (!is_last) begin
                    state_next = msc_pkg::ST_RD;
                end else if (step_reg + 7'd1 >= steps_eff) begin
                    state_next = msc_pkg::ST_DONE;
                end else begin
                    state_next = msc_pkg::ST_SS0;
                end
            end
            msc_pkg::ST_DONE: state_next = msc_pkg::ST_IDLE;
            default: state_next = msc_pkg::ST_IDLE;
        endcase
    end

    // Memory control and datapath.
    always_comb begin
        pos_we    = 1'b0;
        vel_we    = 1'b0;
        pos_waddr = NW'(cmd.node_index);
        vel_waddr = NW'(cmd.node_index);
        pos_wdata = set_val;
        vel_wdata = set_val;
        pos_raddr = NW'(i_reg + NW'(1));
        vel_raddr = i_reg;
        i_next    = i_reg;
        step_next = step_reg;
        xl_next   = xl_reg;
        xc_next   = xc_reg;
        xr_next   = xr_reg;
        v_next    = v_reg;
        acc_next  = acc_reg;
        pos1_next = pos1_reg;
        pv_next   = pv_reg;
        vv_next   = vv_reg;
        case (state_reg)
            msc_pkg::ST_IDLE: begin
                step_next = '0;
                if (cmd.start && set_ok) begin
                    if (cmd.func == msc_pkg::FUNC_SET_POS) begin
                        pos_we = 1'b1;
                        pv_next[NW'(cmd.node_index)] = 1'b1;
                        if (NW'(cmd.node_index) == NW'(1)) begin
                            pos1_next = set_val;
                        end
                    end else if (cmd.func == msc_pkg::FUNC_SET_VEL) begin
                        vel_we = 1'b1;
                        vv_next[NW'(cmd.node_index)] = 1'b1;
                    end
                end
            end
            msc_pkg::ST_SS0: pos_raddr = '0;
            msc_pkg::ST_SS1: begin
                pos_raddr = NW'(1);
                xl_next   = pos_rd;
            end
            msc_pkg::ST_SS2: begin
                xc_next = pos_rd;
                i_next  = NW'(1);
            end
            msc_pkg::ST_CAP: begin
                xr_next = pos_rd;
                v_next  = vel_rd;
            end
            msc_pkg::ST_K:  acc_next = mul_res;
            msc_pkg::ST_D:  acc_next = acc_reg - mul_res;
            msc_pkg::ST_IM: acc_next = mul_res;
            msc_pkg::ST_V:  v_next   = v_reg + mul_res;
            msc_pkg::ST_X: begin
                pos_we    = 1'b1;
                vel_we    = 1'b1;
                pos_waddr = i_reg;
                vel_waddr = i_reg;
                pos_wdata = x_new;
                vel_wdata = v_reg;
                pv_next[i_reg] = 1'b1;
                vv_next[i_reg] = 1'b1;
                if (i_reg == NW'(1)) begin
                    pos1_next = x_new;
                end
                xl_next = xc_reg;
                xc_next = xr_reg;
                i_next  = NW'(i_reg + NW'(1));
                if (is_last) begin
                    step_next = step_reg + 7'd1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= msc_pkg::ST_IDLE;
            pv_reg    <= '0;
            vv_reg    <= '0;
            pos1_reg  <= '0;
            step_reg  <= '0;
            i_reg     <= '0;
        end else begin
            state_reg <= state_next;
            pv_reg    <= pv_next;
            vv_reg    <= vv_next;
            pos1_reg  <= pos1_next;
            step_reg  <= step_next;
            i_reg     <= i_next;
        end
        pvq_reg <= pv_reg[pos_raddr];
        vvq_reg <= vv_reg[vel_raddr];
        xl_reg  <= xl_next;
        xc_reg  <= xc_next;
        xr_reg  <= xr_next;
        v_reg   <= v_next;
        acc_reg <= acc_next;
    end

    assign status.idle = (state_reg == msc_pkg::ST_IDLE);
    assign status.done = (state_reg == msc_pkg::ST_DONE);
    assign pos1        = pos1_reg;

endmodule

### src/msc_checker.sv
// Port-level checker for the mass-spring chain block, bound to the top level.
// Depends on the assertion macro header.
`timescale 1ns / 1ps
`include "mass_spring_chain_euler_step_top_macros.svh"

module msc_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [31:0] m_sample
);

    `MSC_ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_sample), "result changed while stalled")
    `MSC_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_valid && s_ready, !s_ready, "request taken while busy")
    `MSC_ASSERT_NOW(a_slot_free, aclk, aresetn, s_ready, !m_valid || m_ready, "request taken with result slot full")

endmodule

bind mass_spring_chain_euler_step_top msc_checker u_msc_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_sample(m_sample)
);
